FILE: design/upa_pkg.sv
// shared constants, status codes and control types for the unit pool allocator
package upa_pkg;

    localparam int POOL_UNITS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int UNIT_W      = 4;
    localparam int CNT_W       = 5;
    localparam int STATUS_W    = 2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd3;

    typedef struct packed {
        logic load;
        logic emit_bad;
        logic emit_short;
        logic release_unit;
        logic alloc_start;
        logic grant;
    } upa_cmd_t;

    typedef struct packed {
        logic op_release;
        logic req_bad;
        logic req_short;
        logic rel_ok;
        logic last_grant;
        logic any_free;
    } upa_sts_t;

endpackage

FILE: design/unit_pool_allocator_top.sv
// top level of the unit pool allocator
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  request  | start in, busy out   | op, count, unit
//  result   | strobe out           | unit_index, status, last, free_units
//
//  a request is taken at a clock edge with start high and busy low
//  release, bad request and insufficient: check state, then registered result
//  allocate of n units: a check state, then one grant per cycle
//  from the priority scan over the busy map
//  the next request can be taken in the cycle the final result is shown
//  reset restores an all-free pool; results cannot be stalled by the receiver
module unit_pool_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [upa_pkg::CNT_W-1:0]     count,
    input  logic [upa_pkg::UNIT_W-1:0]    unit,
    output logic                          strobe,
    output logic [upa_pkg::UNIT_W-1:0]    unit_index,
    output logic [upa_pkg::STATUS_W-1:0]  status,
    output logic                          last,
    output logic [upa_pkg::CNT_W-1:0]     free_units
);
    import upa_pkg::*;

    // command and status between controller and datapath
    upa_cmd_t cmd;
    upa_sts_t sts;

    // sequencer: idle, request check, then one grant per cycle
    upa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // pool state, lowest-free scan and registered result
    upa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .count      (count),
        .unit       (unit),
        .cmd        (cmd),
        .sts        (sts),
        .strobe     (strobe),
        .unit_index (unit_index),
        .status     (status),
        .last       (last),
        .free_units (free_units)
    );

endmodule

FILE: design/upa_ctrl.sv
// controller state machine for the unit pool allocator
module upa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  upa_pkg::upa_sts_t sts,
    output upa_pkg::upa_cmd_t cmd,
    output logic            busy
);
    import upa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_GRANT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (sts.op_release)
                begin
                    if (sts.rel_ok)
                    begin
                        cmd.release_unit = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_bad = 1'b1;
                    end
                end
                else if (sts.req_bad)
                begin
                    cmd.emit_bad = 1'b1;
                end
                else if (sts.req_short)
                begin
                    cmd.emit_short = 1'b1;
                end
                else
                begin
                    cmd.alloc_start = 1'b1;
                    state_next      = S_GRANT;
                end
            end
            S_GRANT:
            begin
                cmd.grant = 1'b1;
                if (sts.last_grant)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // a grant cycle always finds a free unit
    a_grant_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT) |-> sts.any_free)
        else $error("grant cycle with no free unit");

    // a grant run ends exactly when the last unit goes out
    a_grant_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT && sts.last_grant) |=> (state_reg == S_IDLE))
        else $error("grant run did not end after last unit");

    // state always holds one of the defined codes
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) || (state_reg == S_CHECK) || (state_reg == S_GRANT))
        else $error("controller in undefined state");

endmodule

FILE: design/upa_datapath.sv
// busy bitmap, free count, free-unit scan and result registers
module upa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op,
    input  logic [upa_pkg::CNT_W-1:0]     count,
    input  logic [upa_pkg::UNIT_W-1:0]    unit,
    input  upa_pkg::upa_cmd_t             cmd,
    output upa_pkg::upa_sts_t             sts,
    output logic                          strobe,
    output logic [upa_pkg::UNIT_W-1:0]    unit_index,
    output logic [upa_pkg::STATUS_W-1:0]  status,
    output logic                          last,
    output logic [upa_pkg::CNT_W-1:0]     free_units
);
    import upa_pkg::*;

    logic                  op_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [UNIT_W-1:0]     unit_reg;
    logic [POOL_UNITS-1:0] busy_map_reg;
    logic [CNT_W-1:0]      free_count_reg;
    logic [CNT_W-1:0]      remain_reg;
    logic                  strobe_reg;
    logic [UNIT_W-1:0]     unit_index_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      free_units_reg;

    logic [UNIT_W-1:0]     free_idx;
    logic                  any_free;

    // lowest free unit
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = POOL_UNITS - 1; i >= 0; i--)
        begin
            if (!busy_map_reg[i])
            begin
                free_idx = UNIT_W'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.op_release = (op_reg == OP_RELEASE);
        sts.req_bad    = (count_reg == '0) || (count_reg > CNT_W'(POOL_UNITS))
                         || (count_reg > CNT_W'(MAX_RESULTS));
        sts.req_short  = (count_reg > free_count_reg);
        sts.rel_ok     = ({1'b0, unit_reg} < CNT_W'(POOL_UNITS))
                         && busy_map_reg[unit_reg];
        sts.last_grant = (remain_reg == CNT_W'(1));
        sts.any_free   = any_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_map_reg   <= '0;
            free_count_reg <= CNT_W'(POOL_UNITS);
            remain_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_bad | cmd.emit_short | cmd.release_unit | cmd.grant;
            if (cmd.release_unit)
            begin
                busy_map_reg[unit_reg] <= 1'b0;
                free_count_reg         <= free_count_reg + CNT_W'(1);
            end
            if (cmd.alloc_start)
            begin
                remain_reg     <= count_reg;
                free_count_reg <= free_count_reg - count_reg;
            end
            if (cmd.grant)
            begin
                busy_map_reg[free_idx] <= 1'b1;
                remain_reg             <= remain_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            count_reg <= count;
            unit_reg  <= unit;
        end
        if (cmd.emit_bad || cmd.emit_short)
        begin
            unit_index_reg <= '0;
            status_reg     <= cmd.emit_bad ? ST_BAD : ST_SHORT;
            last_reg       <= 1'b1;
            free_units_reg <= free_count_reg;
        end
        else if (cmd.release_unit)
        begin
            unit_index_reg <= unit_reg;
            status_reg     <= ST_RELEASED;
            last_reg       <= 1'b1;
            free_units_reg <= free_count_reg + CNT_W'(1);
        end
        else if (cmd.grant)
        begin
            unit_index_reg <= free_idx;
            status_reg     <= ST_GRANTED;
            last_reg       <= (remain_reg == CNT_W'(1));
            free_units_reg <= free_count_reg;
        end
    end

    assign strobe     = strobe_reg;
    assign unit_index = unit_index_reg;
    assign status     = status_reg;
    assign last       = last_reg;
    assign free_units = free_units_reg;

    // free count plus units still owed equals the number of clear bits
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(~busy_map_reg) == (int'(free_count_reg) + int'(remain_reg)))
        else $error("free count out of step with busy map");

    // free count never exceeds the pool
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CNT_W'(POOL_UNITS))
        else $error("free count above pool size");

    // only grants come without last
    a_nonlast_is_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> (status_reg == ST_GRANTED))
        else $error("non-final result that is not a grant");

    // a granted unit is busy right after its result goes out
    a_grant_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |=> busy_map_reg[unit_index_reg])
        else $error("granted unit not marked busy");

endmodule
